// ----- src/lpht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int KEY_W = 31;
	localparam int VAL_W = 32;
	localparam int CNT_W = 8;
	localparam int CMD_W = 2;

	localparam logic [VAL_W-1:0] ABSENT_VALUE = 32'h8000_0000;
	localparam logic [CNT_W-1:0] MAX_RESET    = 8'd204;

	// Command codes; the spare code behaves as a lookup.
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_ERASE  = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_SPARE  = 2'd3
	} cmd_t;

	// Back end sequencer states.
	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_PRD,
		BK_PCHK,
		BK_ERD,
		BK_ECHK,
		BK_EFIN
	} back_state_t;

	// Status from the back end to the front end.
	typedef struct packed {
		logic clearing;
	} back_status_t;

endpackage

// ----- src/lpht_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_if
// Handshake channels of the hash table: commands, results and configuration.
// ----------------------------------------------------------------------------
interface lpht_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [lpht_pkg::CMD_W-1:0] command;
	logic [lpht_pkg::KEY_W-1:0] key;
	logic [lpht_pkg::VAL_W-1:0] value;
	modport source (output valid, command, key, value, input ready);
	modport sink   (input valid, command, key, value, output ready);
endinterface

interface lpht_res_if;
	logic                       valid;
	logic                       ready;
	logic                       found;
	logic [lpht_pkg::VAL_W-1:0] old_value;
	logic                       status;
	logic [lpht_pkg::CNT_W-1:0] entry_count;
	modport source (output valid, found, old_value, status, entry_count, input ready);
	modport sink   (input valid, found, old_value, status, entry_count, output ready);
endinterface

interface lpht_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [lpht_pkg::CNT_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ----- src/lpht_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_front
// Accepts commands and works out the home slot, key modulo CAPACITY, by
// multiplying with a fixed reciprocal.
// ----------------------------------------------------------------------------
module lpht_front #(
	parameter int CAPACITY = 256,
	parameter int IW       = $clog2(CAPACITY),
	parameter int QW       = lpht_pkg::CMD_W + lpht_pkg::KEY_W + lpht_pkg::VAL_W + IW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	lpht_cmd_if.sink              request,
	input  lpht_pkg::back_status_t bstat,
	output logic                  push,
	output logic [QW-1:0]         push_data,
	input  logic                  full
);

	// Rounded-up reciprocal: exact quotient for every 31-bit key.
	localparam int PW = lpht_pkg::KEY_W + 32;
	localparam logic [63:0] RECIP_WIDE =
		((64'd1 << (lpht_pkg::KEY_W + IW)) + 64'(CAPACITY) - 64'd1) / 64'(CAPACITY);
	localparam logic [31:0] RECIP = RECIP_WIDE[31:0];
	localparam logic [IW:0] CAP_C = (IW + 1)'(CAPACITY);

	logic                         busy_q;
	logic                         done_q;
	logic [1:0]                   cnt_q;
	logic [lpht_pkg::KEY_W-1:0]   quo_q;
	logic [lpht_pkg::KEY_W-1:0]   qc_q;
	logic [IW-1:0]                home_q;
	logic [PW-1:0]                prod;
	logic [PW-1:0]                prod_sh;
	logic [lpht_pkg::KEY_W+IW:0]  qc_full;
	logic [lpht_pkg::KEY_W-1:0]   rem;
	logic [lpht_pkg::CMD_W-1:0]   cmd_q;
	logic [lpht_pkg::KEY_W-1:0]   key_q;
	logic [lpht_pkg::VAL_W-1:0]   val_q;

	// Accept a beat only while free and once the table has been cleared.
	assign request.ready = !busy_q && !done_q && !bstat.clearing;
	assign push          = done_q && !full;
	assign push_data     = {cmd_q, key_q, val_q, home_q};

	// Quotient by reciprocal, product back and remainder.
	assign prod    = {32'd0, key_q} * {31'd0, RECIP};
	assign prod_sh = prod >> (lpht_pkg::KEY_W + IW);
	assign qc_full = {{(IW + 1){1'b0}}, quo_q} * {{lpht_pkg::KEY_W{1'b0}}, CAP_C};
	assign rem     = key_q - qc_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (request.valid && request.ready) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (push) begin
				done_q <= 1'b0;
			end
		end
	end

	// Item and home slot registers.
	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			cmd_q <= request.command;
			key_q <= request.key;
			val_q <= request.value;
		end else if (busy_q) begin
			case (cnt_q)
				2'd0:    quo_q  <= prod_sh[lpht_pkg::KEY_W-1:0];
				2'd1:    qc_q   <= qc_full[lpht_pkg::KEY_W-1:0];
				default: home_q <= rem[IW-1:0];
			endcase
		end
	end

endmodule

// ----- src/lpht_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_fifo
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lpht_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         not_empty
);

	logic [W-1:0] buf_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign pop_data  = buf_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= push_data;
		end
	end

endmodule

// ----- src/lpht_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_back
// Probes the slot memory, carries out insert, erase with backward shift and
// lookup, and holds the result register.
// ----------------------------------------------------------------------------
module lpht_back #(
	parameter int CAPACITY = 256,
	parameter int IW       = $clog2(CAPACITY),
	parameter int QW       = lpht_pkg::CMD_W + lpht_pkg::KEY_W + lpht_pkg::VAL_W + IW
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [QW-1:0]              pop_data,
	input  logic                       not_empty,
	output logic                       pop,
	input  logic [lpht_pkg::CNT_W-1:0] max_entries,
	output lpht_pkg::back_status_t     bstat,
	lpht_res_if.source                 response
);

	localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
	localparam logic [IW:0]   CAP_N     = (IW + 1)'(CAPACITY);

	typedef struct packed {
		logic                       valid;
		logic [IW-1:0]              home;
		logic [lpht_pkg::KEY_W-1:0] key;
		logic [lpht_pkg::VAL_W-1:0] value;
	} entry_t;

	entry_t mem [CAPACITY];
	entry_t rdata_s1;

	lpht_pkg::back_state_t st_q, st_d;

	logic [IW:0]                n_q;
	logic [IW-1:0]              i_q;
	logic [IW-1:0]              gap_q;
	logic [IW-1:0]              home_q;
	logic [lpht_pkg::CMD_W-1:0] cmd_q;
	logic [lpht_pkg::KEY_W-1:0] key_q;
	logic [lpht_pkg::VAL_W-1:0] val_q;
	logic [lpht_pkg::CNT_W-1:0] count_q;
	logic [lpht_pkg::VAL_W-1:0] old_q;

	logic                       rv_q;
	logic                       rfound_q;
	logic [lpht_pkg::VAL_W-1:0] rold_q;
	logic                       rstat_q;
	logic [lpht_pkg::CNT_W-1:0] rcnt_q;

	logic                       we;
	logic [IW-1:0]              waddr;
	entry_t                     wdata;
	logic [IW-1:0]              raddr;
	logic [IW-1:0]              i_next;
	logic                       hit;
	logic                       miss;
	logic                       scan_end;
	logic                       resolve;
	logic                       ins_new;
	logic                       between;
	logic                       emit;
	logic                       emit_found;
	logic [lpht_pkg::VAL_W-1:0] emit_old;
	logic                       emit_stat;
	logic [lpht_pkg::CNT_W-1:0] emit_cnt;

	assign bstat.clearing = st_q == lpht_pkg::BK_CLEAR;

	assign response.valid       = rv_q;
	assign response.found       = rfound_q;
	assign response.old_value   = rold_q;
	assign response.status      = rstat_q;
	assign response.entry_count = rcnt_q;

	// Take a new item only when the result register will be free.
	assign pop = st_q == lpht_pkg::BK_IDLE && not_empty && (!rv_q || response.ready);

	// Probe classification of the slot just read.
	assign i_next  = (i_q == LAST_SLOT) ? '0 : i_q + 1'b1;
	assign hit     = rdata_s1.valid && rdata_s1.key == key_q;
	assign miss    = !rdata_s1.valid;
	assign resolve = hit || miss || n_q == {1'b0, LAST_SLOT};
	assign ins_new = !hit && miss && count_q < max_entries;

	// The shift scan ends at an empty slot or on wrapping round to the gap,
	// whose memory word still holds the entry that was moved out of it.
	assign scan_end = miss || i_q == gap_q;

	// Home of the examined entry inside the cyclic interval (gap, slot].
	always_comb begin
		if (gap_q <= i_q) begin
			between = gap_q < rdata_s1.home && rdata_s1.home <= i_q;
		end else begin
			between = gap_q < rdata_s1.home || rdata_s1.home <= i_q;
		end
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			lpht_pkg::BK_CLEAR: begin
				if (n_q == {1'b0, LAST_SLOT}) begin
					st_d = lpht_pkg::BK_IDLE;
				end
			end
			lpht_pkg::BK_IDLE: begin
				if (pop) begin
					st_d = lpht_pkg::BK_PRD;
				end
			end
			lpht_pkg::BK_PRD: st_d = lpht_pkg::BK_PCHK;
			lpht_pkg::BK_PCHK: begin
				if (!resolve) begin
					st_d = lpht_pkg::BK_PRD;
				end else if (cmd_q == lpht_pkg::CMD_ERASE && hit) begin
					st_d = lpht_pkg::BK_ERD;
				end else begin
					st_d = lpht_pkg::BK_IDLE;
				end
			end
			lpht_pkg::BK_ERD: st_d = lpht_pkg::BK_ECHK;
			lpht_pkg::BK_ECHK: begin
				if (scan_end || n_q == CAP_N) begin
					st_d = lpht_pkg::BK_EFIN;
				end else begin
					st_d = lpht_pkg::BK_ERD;
				end
			end
			lpht_pkg::BK_EFIN: st_d = lpht_pkg::BK_IDLE;
			default: st_d = lpht_pkg::BK_IDLE;
		endcase
	end

	// Memory port and result outputs.
	always_comb begin
		we         = 1'b0;
		waddr      = i_q;
		wdata      = '0;
		raddr      = i_q;
		emit       = 1'b0;
		emit_found = hit;
		emit_old   = hit ? rdata_s1.value : lpht_pkg::ABSENT_VALUE;
		emit_stat  = 1'b0;
		emit_cnt   = count_q;
		case (st_q)
			lpht_pkg::BK_CLEAR: begin
				we    = 1'b1;
				waddr = n_q[IW-1:0];
			end
			lpht_pkg::BK_PCHK: begin
				if (resolve) begin
					if (cmd_q == lpht_pkg::CMD_INSERT) begin
						emit  = 1'b1;
						wdata = '{valid: 1'b1, home: home_q, key: key_q, value: val_q};
						if (hit) begin
							we = 1'b1;
						end else if (ins_new) begin
							we       = 1'b1;
							emit_cnt = count_q + 1'b1;
						end else begin
							emit_stat = 1'b1;
						end
					end else if (cmd_q == lpht_pkg::CMD_ERASE && hit) begin
						we = 1'b1;
					end else begin
						emit = 1'b1;
					end
				end
			end
			lpht_pkg::BK_ERD: begin
				raddr = i_next;
			end
			lpht_pkg::BK_ECHK: begin
				if (!scan_end && !between) begin
					we    = 1'b1;
					waddr = gap_q;
					wdata = rdata_s1;
				end
			end
			lpht_pkg::BK_EFIN: begin
				we         = 1'b1;
				waddr      = gap_q;
				emit       = 1'b1;
				emit_found = 1'b1;
				emit_old   = old_q;
				emit_cnt   = (count_q != '0) ? count_q - 1'b1 : count_q;
			end
			default: begin
				raddr = i_q;
			end
		endcase
	end

	// Slot memory with registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= lpht_pkg::BK_CLEAR;
			n_q     <= '0;
			count_q <= '0;
			rv_q    <= 1'b0;
		end else begin
			st_q <= st_d;
			if (response.ready) begin
				rv_q <= 1'b0;
			end
			if (emit) begin
				rv_q    <= 1'b1;
				count_q <= emit_cnt;
			end
			case (st_q)
				lpht_pkg::BK_CLEAR: n_q <= n_q + 1'b1;
				lpht_pkg::BK_IDLE:  n_q <= '0;
				lpht_pkg::BK_PCHK: begin
					n_q <= resolve ? '0 : n_q + 1'b1;
				end
				lpht_pkg::BK_ERD:   n_q <= n_q + 1'b1;
				default:            n_q <= n_q;
			endcase
		end
	end

	// Item, cursor and result payload registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			{cmd_q, key_q, val_q, home_q} <= pop_data;
			i_q <= pop_data[IW-1:0];
		end else if (st_q == lpht_pkg::BK_PCHK) begin
			if (!resolve) begin
				i_q <= i_next;
			end
			gap_q <= i_q;
			old_q <= rdata_s1.value;
		end else if (st_q == lpht_pkg::BK_ERD) begin
			i_q <= i_next;
		end else if (st_q == lpht_pkg::BK_ECHK && !scan_end && !between) begin
			gap_q <= i_q;
		end
		if (emit) begin
			rfound_q <= emit_found;
			rold_q   <= emit_old;
			rstat_q  <= emit_stat;
			rcnt_q   <= emit_cnt;
		end
	end

endmodule

// ----- src/linear_probe_hash_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing key/value table with linear probing and backward shift
// erase, built as a reducing front end, a queue and a probing back end.
// ----------------------------------------------------------------------------
// Channel    Modport  Beat carries
// request    sink     command, key, value
// response   source   found, old_value, status, entry_count
// cfg        sink     max_entries
//
// The front end works out the home slot of each command (reciprocal
// multiply, multiply back, subtract) and then hands it to the queue;
// it takes no new command until that handoff is done.
// The back end takes an item from the queue, then reads and checks each
// slot probed; an erase then reads and checks each slot scanned and
// closes the gap in a final step.
// After reset a clearing pass writes every slot empty; no command is
// taken meanwhile, configuration writes are.
// A stalled response holds the back end; the queue lets the front go on.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
	parameter int CAPACITY = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	lpht_cmd_if.sink   request,
	lpht_res_if.source response,
	lpht_cfg_if.sink   cfg
);

	localparam int IW = $clog2(CAPACITY);
	localparam int QW = lpht_pkg::CMD_W + lpht_pkg::KEY_W + lpht_pkg::VAL_W + IW;

	logic [lpht_pkg::CNT_W-1:0] max_q;
	logic                       push;
	logic [QW-1:0]              push_data;
	logic                       full;
	logic                       pop;
	logic [QW-1:0]              pop_data;
	logic                       not_empty;
	lpht_pkg::back_status_t     bstat;

	// Entry limit register.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= lpht_pkg::MAX_RESET;
		end else if (cfg.valid) begin
			max_q <= cfg.data;
		end
	end

	lpht_front #(.CAPACITY(CAPACITY), .IW(IW), .QW(QW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.bstat     (bstat),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	lpht_fifo #(.W(QW)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	lpht_back #(.CAPACITY(CAPACITY), .IW(IW), .QW(QW)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_data    (pop_data),
		.not_empty   (not_empty),
		.pop         (pop),
		.max_entries (max_q),
		.bstat       (bstat),
		.response    (response)
	);

endmodule

// ----- src/lpht_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_checker
// Port level checks of the hash table results, bound to the top level.
// ----------------------------------------------------------------------------
module lpht_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic                       rsp_found,
	input logic [lpht_pkg::VAL_W-1:0] rsp_old,
	input logic                       rsp_status
);

	// A stalled result keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_old) && $stable(rsp_found))
		else $error("result changed while stalled");

	// A rejected insert only happens for a key that was absent.
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status |-> !rsp_found)
		else $error("rejection reported for a present key");

	// An absent key reports the absent marker value.
	a_absent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_old == lpht_pkg::ABSENT_VALUE)
		else $error("absent key without absent marker");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (response.valid),
	.rsp_ready  (response.ready),
	.rsp_found  (response.found),
	.rsp_old    (response.old_value),
	.rsp_status (response.status)
);
